FILE: rtl/vdu_command_stream_framer_top_macros.svh
// ----------------------------------------------------------------------------
// VDU framer assertion macros
// Shared concurrent assertion forms for the framer's checker.
// ----------------------------------------------------------------------------
`ifndef VDU_COMMAND_STREAM_FRAMER_TOP_MACROS_SVH
`define VDU_COMMAND_STREAM_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define VCSF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define VCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vcsf_pkg.sv
// ----------------------------------------------------------------------------
// VDU framer package
// Types, control codes and the command length table shared by the framer.
// ----------------------------------------------------------------------------
package vcsf_pkg;

  // Parameter store depth; must be at least the longest command (9), at most 16
  localparam int MAX_PARAMS  = 9;
  localparam int IDX_W       = $clog2(MAX_PARAMS);
  localparam int PARAM_SLOTS = 9;
  localparam int COUNT_W     = 4;

  localparam logic [7:0] PRINT_MIN = 8'd32;

  // Immediate control codes
  localparam logic [7:0] CODE_BACKSPACE  = 8'd8;
  localparam logic [7:0] CODE_LINE_FEED  = 8'd10;
  localparam logic [7:0] CODE_CLEAR_TEXT = 8'd12;
  localparam logic [7:0] CODE_CARRIAGE   = 8'd13;
  localparam logic [7:0] CODE_CLEAR_GFX  = 8'd16;

  // Codes that open a parameterized command
  localparam logic [7:0] CODE_TEXT_COLOR  = 8'd17;
  localparam logic [7:0] CODE_GFX_COLOR   = 8'd18;
  localparam logic [7:0] CODE_PALETTE     = 8'd19;
  localparam logic [7:0] CODE_MODE        = 8'd22;
  localparam logic [7:0] CODE_DEFINE_CHAR = 8'd23;
  localparam logic [7:0] CODE_GFX_WINDOW  = 8'd24;
  localparam logic [7:0] CODE_PLOT        = 8'd25;
  localparam logic [7:0] CODE_TEXT_WINDOW = 8'd28;
  localparam logic [7:0] CODE_GFX_ORIGIN  = 8'd29;
  localparam logic [7:0] CODE_TAB         = 8'd31;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_IMMEDIATE = 2'd1,
    KIND_COMMAND   = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    kind_t                         kind;
    logic [7:0]                    code;
    logic [COUNT_W-1:0]            count;
    logic [PARAM_SLOTS-1:0][7:0]   params;
  } result_t;

  function automatic logic is_immediate(input logic [7:0] c);
    return (c == CODE_BACKSPACE) || (c == CODE_LINE_FEED) || (c == CODE_CLEAR_TEXT) ||
           (c == CODE_CARRIAGE) || (c == CODE_CLEAR_GFX);
  endfunction

  // Parameter bytes a command needs; zero for anything that starts no command
  function automatic logic [COUNT_W-1:0] start_length(input logic [7:0] c);
    logic [COUNT_W-1:0] n;
    case (c)
      CODE_TEXT_COLOR:  n = 4'd1;
      CODE_GFX_COLOR:   n = 4'd2;
      CODE_PALETTE:     n = 4'd5;
      CODE_MODE:        n = 4'd1;
      CODE_DEFINE_CHAR: n = 4'd9;
      CODE_GFX_WINDOW:  n = 4'd8;
      CODE_PLOT:        n = 4'd5;
      CODE_TEXT_WINDOW: n = 4'd4;
      CODE_GFX_ORIGIN:  n = 4'd4;
      CODE_TAB:         n = 4'd2;
      default:          n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/vcsf_if.sv
// ----------------------------------------------------------------------------
// VDU framer channels
// Valid/ready channels for the input byte stream and the framed items.
// ----------------------------------------------------------------------------
interface vcsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface vcsf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] code;
  logic [3:0] param_count;
  logic [7:0] param_0;
  logic [7:0] param_1;
  logic [7:0] param_2;
  logic [7:0] param_3;
  logic [7:0] param_4;
  logic [7:0] param_5;
  logic [7:0] param_6;
  logic [7:0] param_7;
  logic [7:0] param_8;

  modport source (
    output valid, output item_kind, output code, output param_count,
    output param_0, output param_1, output param_2, output param_3, output param_4,
    output param_5, output param_6, output param_7, output param_8,
    input ready
  );
  modport sink (
    input valid, input item_kind, input code, input param_count,
    input param_0, input param_1, input param_2, input param_3, input param_4,
    input param_5, input param_6, input param_7, input param_8,
    output ready
  );
endinterface

FILE: rtl/vcsf_input_stage.sv
// ----------------------------------------------------------------------------
// VDU framer input stage
// Registers each incoming byte and hands it to the collector.
// ----------------------------------------------------------------------------
module vcsf_input_stage (
  input  logic             clk,
  input  logic             rst,
  vcsf_byte_if.sink        stream,
  input  logic             free,
  output vcsf_pkg::stage_t cur,
  output logic             take
);

  vcsf_pkg::stage_t stage;

  assign take         = stage.valid && free;
  assign stream.ready = !stage.valid || free;
  assign cur          = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (stream.ready) begin
      stage.valid <= stream.valid;
    end
    if (stream.valid && stream.ready) begin
      stage.data <= stream.stream_byte;
    end
  end

endmodule

FILE: rtl/vcsf_collector.sv
// ----------------------------------------------------------------------------
// VDU framer collector
// Classifies each byte, tracks the pending command and frames results.
// ----------------------------------------------------------------------------
module vcsf_collector (
  input  logic              clk,
  input  logic              rst,
  input  vcsf_pkg::stage_t  cur,
  input  logic              take,
  output logic              res_valid,
  output vcsf_pkg::result_t res
);

  logic [7:0]                   pending_code;
  logic [7:0]                   pending_code_next;
  logic [vcsf_pkg::COUNT_W-1:0] needed_length;
  logic [vcsf_pkg::COUNT_W-1:0] needed_length_next;
  logic [vcsf_pkg::COUNT_W-1:0] byte_index;
  logic [vcsf_pkg::COUNT_W-1:0] byte_index_next;
  logic [7:0]                   param_store [vcsf_pkg::MAX_PARAMS];

  logic [vcsf_pkg::COUNT_W-1:0] index_inc;
  logic [vcsf_pkg::COUNT_W-1:0] start_len;
  logic                         pending;

  assign pending   = needed_length != '0;
  assign index_inc = byte_index + 1'b1;
  assign start_len = vcsf_pkg::start_length(cur.data);

  always_comb begin
    pending_code_next  = pending_code;
    needed_length_next = needed_length;
    byte_index_next    = byte_index;
    res_valid          = 1'b0;
    res.kind           = vcsf_pkg::KIND_CHAR;
    res.code           = cur.data;
    res.count          = '0;
    res.params         = '0;

    if (pending) begin
      byte_index_next = index_inc;
      res.kind        = vcsf_pkg::KIND_COMMAND;
      res.code        = pending_code;
      res.count       = needed_length;
      // The byte arriving now fills its slot directly; earlier ones come from the store
      for (int i = 0; i < vcsf_pkg::PARAM_SLOTS; i++) begin
        if (i < int'(needed_length)) begin
          res.params[i] = (i == int'(byte_index)) ? cur.data : param_store[i];
        end
      end
      if (index_inc == needed_length) begin
        res_valid          = 1'b1;
        pending_code_next  = '0;
        needed_length_next = '0;
        byte_index_next    = '0;
      end
    end else if (cur.data >= vcsf_pkg::PRINT_MIN) begin
      res_valid = 1'b1;
    end else if (vcsf_pkg::is_immediate(cur.data)) begin
      res_valid = 1'b1;
      res.kind  = vcsf_pkg::KIND_IMMEDIATE;
    end else if (start_len != '0) begin
      pending_code_next  = cur.data;
      needed_length_next = start_len;
      byte_index_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_code  <= '0;
      needed_length <= '0;
      byte_index    <= '0;
    end else if (take) begin
      pending_code  <= pending_code_next;
      needed_length <= needed_length_next;
      byte_index    <= byte_index_next;
    end
  end

  // Every slot a command reports is written before it is read, so no clear
  always_ff @(posedge clk) begin
    if (take && pending && (int'(byte_index) < vcsf_pkg::MAX_PARAMS)) begin
      param_store[byte_index[vcsf_pkg::IDX_W-1:0]] <= cur.data;
    end
  end

endmodule

FILE: rtl/vcsf_output_stage.sv
// ----------------------------------------------------------------------------
// VDU framer output stage
// Result register that holds a framed item until the sink takes it.
// ----------------------------------------------------------------------------
module vcsf_output_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  vcsf_pkg::result_t res,
  output logic              free,
  vcsf_item_if.source       items
);

  logic              held;
  vcsf_pkg::result_t data;

  assign free = !held || items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (free) begin
      held <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= res;
    end
  end

  assign items.valid       = held;
  assign items.item_kind   = data.kind;
  assign items.code        = data.code;
  assign items.param_count = data.count;
  assign items.param_0     = data.params[0];
  assign items.param_1     = data.params[1];
  assign items.param_2     = data.params[2];
  assign items.param_3     = data.params[3];
  assign items.param_4     = data.params[4];
  assign items.param_5     = data.params[5];
  assign items.param_6     = data.params[6];
  assign items.param_7     = data.params[7];
  assign items.param_8     = data.params[8];

endmodule

FILE: rtl/vdu_command_stream_framer_top.sv
// The framer takes at most one byte of a terminal output stream per cycle and
// emits at most one framed item per byte: a printable character, an immediate
// control code, or a completed command with up to nine parameter bytes.
// Sustained rate is one byte per clock while the item sink is ready; each byte
// passes through the input register and then the result register before its
// item appears. The input ready depends combinationally on the output ready,
// through the result register's free condition. Bytes that produce no item
// (dropped control codes, command starts and non-final parameters) never load the result register.
// ----------------------------------------------------------------------------
// VDU command stream framer
// Top level: input register, command collector and result register.
// ----------------------------------------------------------------------------
module vdu_command_stream_framer_top (
  input  logic        clk,
  input  logic        rst,
  vcsf_byte_if.sink   stream,
  vcsf_item_if.source items
);

  vcsf_pkg::stage_t  cur;
  vcsf_pkg::result_t res;
  logic              take;
  logic              free;
  logic              res_valid;

  vcsf_input_stage u_input (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .free   (free),
    .cur    (cur),
    .take   (take)
  );

  vcsf_collector u_collector (
    .clk       (clk),
    .rst       (rst),
    .cur       (cur),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  vcsf_output_stage u_output (
    .clk   (clk),
    .rst   (rst),
    .load  (take && res_valid),
    .res   (res),
    .free  (free),
    .items (items)
  );

endmodule

FILE: rtl/vcsf_checker.sv
// ----------------------------------------------------------------------------
// VDU framer checker
// Port-level assertions on the framed item stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "vdu_command_stream_framer_top_macros.svh"

module vcsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_kind,
  input logic [7:0] code,
  input logic [3:0] param_count,
  input logic [7:0] param_0,
  input logic [7:0] param_1,
  input logic [7:0] param_2,
  input logic [7:0] param_3,
  input logic [7:0] param_4,
  input logic [7:0] param_5,
  input logic [7:0] param_6,
  input logic [7:0] param_7,
  input logic [7:0] param_8
);

  logic [85:0] payload;
  logic        is_char;
  logic        is_imm;
  logic        is_cmd;

  assign payload = {item_kind, code, param_count, param_0, param_1, param_2, param_3,
                    param_4, param_5, param_6, param_7, param_8};
  assign is_char = item_kind == vcsf_pkg::KIND_CHAR;
  assign is_imm  = item_kind == vcsf_pkg::KIND_IMMEDIATE;
  assign is_cmd  = item_kind == vcsf_pkg::KIND_COMMAND;

  `VCSF_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(payload), "stalled item changed")
  `VCSF_ASSERT_IMPLIES(a_char_plain, out_valid && is_char, code >= vcsf_pkg::PRINT_MIN && param_count == 4'd0, "bad character item")
  `VCSF_ASSERT_IMPLIES(a_imm_plain, out_valid && is_imm, vcsf_pkg::is_immediate(code) && param_count == 4'd0, "bad immediate item")
  `VCSF_ASSERT_IMPLIES(a_cmd_framed, out_valid && is_cmd, param_count == vcsf_pkg::start_length(code) && param_count != 4'd0 && (param_count == 4'd9 || param_8 == 8'd0), "bad command item")

endmodule

bind vdu_command_stream_framer_top vcsf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (items.valid),
  .out_ready   (items.ready),
  .item_kind   (items.item_kind),
  .code        (items.code),
  .param_count (items.param_count),
  .param_0     (items.param_0),
  .param_1     (items.param_1),
  .param_2     (items.param_2),
  .param_3     (items.param_3),
  .param_4     (items.param_4),
  .param_5     (items.param_5),
  .param_6     (items.param_6),
  .param_7     (items.param_7),
  .param_8     (items.param_8)
);
